// File: rtl/shbc_pkg.sv
// Shared types, constants and helpers for the sample-and-hold bit crusher.
// Used by shbc_ctrl, shbc_datapath and sample_hold_bit_crusher; no dependencies.
`default_nettype none
package shbc_pkg;

  localparam int NUM_CHANNELS = 2;
  localparam int SAMPLE_BITS  = 24;
  localparam int CH_BITS      = 1;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 26;
  localparam int DIV_STEPS    = 24;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);
  localparam int TANH_POINTS  = 17;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_HOLD_RATIO    = 3'd0,
    REG_INPUT_GAIN    = 3'd1,
    REG_CRUSH_DRIVE   = 3'd2,
    REG_INVERSE_DRIVE = 3'd3,
    REG_QUANT_STEP    = 3'd4,
    REG_OUTPUT_GAIN   = 3'd5,
    REG_WET_GAIN      = 3'd6
  } reg_idx_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_BYPASS,
    OP_GAIN,
    OP_HOLD,
    OP_DRIVE,
    OP_CLIP,
    OP_INTERP,
    OP_TANH,
    OP_DIV,
    OP_QUANT,
    OP_W1,
    OP_OG,
    OP_W2,
    OP_WET,
    OP_DRY,
    OP_MIX,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic bypass;
  } dp_status_t;

  localparam logic [22:0] TANH_TAB [TANH_POINTS] = '{
    23'd0,       23'd2054527, 23'd3876520, 23'd5328017, 23'd6388715,
    23'd7115918, 23'd7592934, 23'd7896830, 23'd8086850, 23'd8204278,
    23'd8276320, 23'd8320322, 23'd8347125, 23'd8363422, 23'd8373323,
    23'd8379334, 23'd8382982
  };

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(input logic signed [43:0] v);
    logic signed [43:0] hi;
    logic signed [43:0] lo;
    hi = 44'sd8388607;
    lo = -44'sd8388608;
    if (v > hi) begin
      return SAMPLE_BITS'(hi);
    end else if (v < lo) begin
      return SAMPLE_BITS'(lo);
    end
    return v[SAMPLE_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/shbc_ctrl.sv
// Sequencer for the sample-and-hold bit crusher: handshakes and datapath steps.
// Depends on shbc_pkg.
`default_nettype none
module shbc_ctrl import shbc_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_GAIN, S_HOLD, S_DRIVE, S_CLIP, S_INTERP, S_TANH, S_DIV,
    S_QUANT, S_W1, S_OG, S_W2, S_WET, S_DRY, S_MIX, S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [DIV_CNT_BITS-1:0] cnt_q, cnt_d;
  logic                    out_valid_q, out_valid_d;
  logic                    finish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign finish      = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_GAIN;
        end
      end
      S_GAIN: begin
        if (status_i.bypass) begin
          cmd_o.op = OP_BYPASS;
          state_d  = S_DONE;
        end else begin
          cmd_o.op = OP_GAIN;
          state_d  = S_HOLD;
        end
      end
      S_HOLD:   begin cmd_o.op = OP_HOLD;   state_d = S_DRIVE;  end
      S_DRIVE:  begin cmd_o.op = OP_DRIVE;  state_d = S_CLIP;   end
      S_CLIP:   begin cmd_o.op = OP_CLIP;   state_d = S_INTERP; end
      S_INTERP: begin cmd_o.op = OP_INTERP; state_d = S_TANH;   end
      S_TANH: begin
        cmd_o.op = OP_TANH;
        cnt_d    = '0;
        state_d  = S_DIV;
      end
      S_DIV: begin
        cmd_o.op = OP_DIV;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
          state_d = S_QUANT;
        end
      end
      S_QUANT: begin cmd_o.op = OP_QUANT; state_d = S_W1;  end
      S_W1:    begin cmd_o.op = OP_W1;    state_d = S_OG;  end
      S_OG:    begin cmd_o.op = OP_OG;    state_d = S_W2;  end
      S_W2:    begin cmd_o.op = OP_W2;    state_d = S_WET; end
      S_WET:   begin cmd_o.op = OP_WET;   state_d = S_DRY; end
      S_DRY:   begin cmd_o.op = OP_DRY;   state_d = S_MIX; end
      S_MIX:   begin cmd_o.op = OP_MIX;   state_d = S_DONE; end
      S_DONE: begin
        if (finish) begin
          cmd_o.op = OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    out_valid_d = finish || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_GAIN))
    else $error("accepted transaction did not start processing");

  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (cnt_q < DIV_CNT_BITS'(DIV_STEPS)))
    else $error("divider step count out of range");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> (out_valid_q && state_q == S_IDLE))
    else $error("finished result not presented");

endmodule
`default_nettype wire

// File: rtl/shbc_datapath.sv
// Datapath of the sample-and-hold bit crusher: config registers, channel state,
// shared multiplier, serial remainder unit and output register. Depends on shbc_pkg.
`default_nettype none
module shbc_datapath import shbc_pkg::*; (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [CFG_IDX_BITS-1:0]       cfg_index_i,
  input  wire [CFG_DATA_BITS-1:0]      cfg_data_i,
  input  wire signed [SAMPLE_BITS-1:0] sample_i,
  input  wire [CH_BITS-1:0]            channel_i,
  input  dp_cmd_t                      cmd_i,
  output dp_status_t                   status_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic                         captured_o
);

  logic [25:0] hold_ratio_q;
  logic [23:0] input_gain_q;
  logic [15:0] crush_drive_q;
  logic [16:0] inverse_drive_q;
  logic [22:0] quant_step_q;
  logic [23:0] output_gain_q;
  logic [16:0] wet_gain_q;

  logic [25:0]                   phase_q [NUM_CHANNELS];
  logic signed [SAMPLE_BITS-1:0] held_q  [NUM_CHANNELS];

  logic signed [SAMPLE_BITS-1:0] dry_q, hv_q, t_q, res_q;
  logic [CH_BITS-1:0]            ch_q;
  logic                          cap_q, res_cap_q, neg_q;
  logic signed [59:0]            prod_q, acc_q;
  logic [22:0]                   y0_q, diff_q;
  logic [20:0]                   f_q;
  logic [23:0]                   num_q, rem_q;
  logic signed [25:0]            w_q;
  logic signed [33:0]            w2_q;

  // Effective (clamped) settings.
  logic [25:0] ratio_eff;
  logic [15:0] drive_eff;
  logic [22:0] step_eff;
  logic        full_wet;
  logic signed [17:0] dry_gain;

  assign ratio_eff = (hold_ratio_q < 26'd65536) ? 26'd65536 : hold_ratio_q;
  assign drive_eff = (crush_drive_q < 16'd8192) ? 16'd8192 : crush_drive_q;
  assign step_eff  = (quant_step_q < 23'd256) ? 23'd256 :
                     ((quant_step_q > 23'd4194304) ? 23'd4194304 : quant_step_q);
  assign full_wet  = (wet_gain_q >= 17'd65530);
  assign dry_gain  = 18'sd65536 - $signed({1'b0, wet_gain_q});

  assign status_o.bypass = (wet_gain_q <= 17'd6) || (32'(ch_q) >= NUM_CHANNELS);

  // Shared multiplier with operand selection.
  logic signed [34:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [59:0] mul_p;
  logic signed [24:0] qlev;

  assign qlev = 25'(t_q) - $signed({1'b0, rem_q});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_GAIN:   begin mul_a = 35'(dry_q); mul_b = $signed({1'b0, input_gain_q}); end
      OP_DRIVE:  begin mul_a = 35'(hv_q);  mul_b = $signed({9'b0, drive_eff}); end
      OP_INTERP: begin mul_a = $signed({12'b0, diff_q}); mul_b = $signed({4'b0, f_q}); end
      OP_QUANT:  begin mul_a = 35'(qlev);  mul_b = $signed({8'b0, inverse_drive_q}); end
      OP_OG:     begin mul_a = 35'(w_q);   mul_b = $signed({1'b0, output_gain_q}); end
      OP_WET:    begin mul_a = 35'(w2_q);  mul_b = $signed({8'b0, wet_gain_q}); end
      OP_DRY:    begin mul_a = 35'(dry_q); mul_b = 25'(dry_gain); end
      default:   begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Rounded views of the product register.
  logic signed [59:0] rnd13, rnd16, mix_sum;
  assign rnd13   = prod_q + 60'sd4096;
  assign rnd16   = prod_q + 60'sd32768;
  assign mix_sum = acc_q + prod_q + 60'sd32768;

  // Hold and phase step.
  logic [26:0]                   phase_inc;
  logic [26:0]                   phase_nxt;
  logic                          do_cap;
  logic signed [SAMPLE_BITS-1:0] g_sat;

  assign g_sat     = sat_sample(rnd16[59:16]);
  assign do_cap    = (phase_q[ch_q] < 26'd65536);
  assign phase_inc = {1'b0, phase_q[ch_q]} + 27'd65536;
  assign phase_nxt = (phase_inc >= {1'b0, ratio_eff}) ? (phase_inc - {1'b0, ratio_eff})
                                                      : phase_inc;

  // Table lookup for the tanh argument.
  logic signed [27:0] a_val;
  logic [27:0]        m_val;
  logic [6:0]         idx_raw;
  logic [4:0]         idx;
  logic [22:0]        y0, y1;

  assign a_val   = rnd13[40:13];
  assign m_val   = a_val[27] ? 28'(-a_val) : a_val;
  assign idx_raw = m_val[27:21];
  assign idx     = (idx_raw >= 7'd16) ? 5'd16 : idx_raw[4:0];
  assign y0      = TANH_TAB[idx];
  assign y1      = (idx == 5'd16) ? TANH_TAB[16] : TANH_TAB[idx + 5'd1];

  // Soft clip result, clamped to the quantizer range.
  logic signed [SAMPLE_BITS-1:0] y_val, t_val, t_hi, t_clamped;
  logic [24:0]                   num_full;

  assign y_val     = $signed({1'b0, y0_q}) + $signed({1'b0, prod_q[43:21]});
  assign t_val     = neg_q ? -y_val : y_val;
  assign t_hi      = 24'sd8388608 - $signed({1'b0, step_eff});
  assign t_clamped = (t_val > t_hi) ? t_hi : t_val;
  assign num_full  = 25'(t_clamped) + 25'd8388608;

  // One restoring step of the remainder of (t + 1) by the step size.
  logic [23:0] rem_sh;
  assign rem_sh = {rem_q[22:0], num_q[23]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_ratio_q    <= 26'd65536;
      input_gain_q    <= 24'd65536;
      crush_drive_q   <= 16'd8192;
      inverse_drive_q <= 17'd65536;
      quant_step_q    <= 23'd4096;
      output_gain_q   <= 24'd65536;
      wet_gain_q      <= 17'd65536;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        phase_q[i] <= '0;
        held_q[i]  <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_index_i))
          REG_HOLD_RATIO:    hold_ratio_q    <= cfg_data_i[25:0];
          REG_INPUT_GAIN:    input_gain_q    <= cfg_data_i[23:0];
          REG_CRUSH_DRIVE:   crush_drive_q   <= cfg_data_i[15:0];
          REG_INVERSE_DRIVE: inverse_drive_q <= cfg_data_i[16:0];
          REG_QUANT_STEP:    quant_step_q    <= cfg_data_i[22:0];
          REG_OUTPUT_GAIN:   output_gain_q   <= cfg_data_i[23:0];
          REG_WET_GAIN:      wet_gain_q      <= cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_HOLD) begin
        phase_q[ch_q] <= phase_nxt[25:0];
        if (do_cap) begin
          held_q[ch_q] <= g_sat;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        dry_q <= sample_i;
        ch_q  <= channel_i;
      end
      OP_BYPASS: begin
        res_q     <= dry_q;
        res_cap_q <= 1'b0;
      end
      OP_GAIN, OP_DRIVE, OP_INTERP, OP_QUANT, OP_OG, OP_WET: prod_q <= mul_p;
      OP_HOLD: begin
        cap_q <= do_cap;
        hv_q  <= do_cap ? g_sat : held_q[ch_q];
      end
      OP_CLIP: begin
        neg_q  <= a_val[27];
        y0_q   <= y0;
        diff_q <= y1 - y0;
        f_q    <= m_val[20:0];
      end
      OP_TANH: begin
        t_q   <= t_clamped;
        num_q <= num_full[23:0];
        rem_q <= '0;
      end
      OP_DIV: begin
        num_q <= {num_q[22:0], 1'b0};
        rem_q <= (rem_sh >= {1'b0, step_eff}) ? (rem_sh - {1'b0, step_eff}) : rem_sh;
      end
      OP_W1: w_q  <= rnd16[41:16];
      OP_W2: w2_q <= rnd16[49:16];
      OP_DRY: begin
        acc_q  <= prod_q;
        prod_q <= mul_p;
      end
      OP_MIX: begin
        res_q     <= full_wet ? sat_sample(44'(w2_q)) : sat_sample(mix_sum[59:16]);
        res_cap_q <= cap_q;
      end
      OP_FINISH: begin
        sample_o   <= res_q;
        captured_o <= res_cap_q;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/sample_hold_bit_crusher.sv
// Top level of the sample-and-hold bit crusher: joins the sequencer and datapath.
// Depends on shbc_pkg, shbc_ctrl and shbc_datapath.
//
// Usage: input samples arrive on the s_axis channel (tdata = sample_in, tuser =
// channel); each accepted transaction produces exactly one result transaction on
// the m_axis channel (tdata = sample_out, tuser = captured). Registers are written
// on the cfg channel, which is always ready; write only while the block is idle.
// An item passes through the sequencer steps from acceptance to a valid result
// (the dry bypass path skips to the end); the quantizer uses the serial remainder
// unit and every product comes from the single shared multiplier. One item is
// processed at a time: the next input is accepted only once the last has finished.
// The result sits in an output register: the next input is accepted while it
// waits, and processing stalls only at the final step until the receiver takes it.
// Reset loads the register defaults, clears phase and held samples of every
// channel and empties the output register.
`default_nettype none
module sample_hold_bit_crusher import shbc_pkg::*; (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  wire [CFG_DATA_BITS-1:0] cfg_data_i,
  input  wire                     s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire [23:0]              s_axis_tdata_i,   // [23:0] sample_in
  input  wire                     s_axis_tuser_i,   // [0] channel
  output logic                    m_axis_tvalid_o,
  input  wire                     m_axis_tready_i,
  output logic [23:0]             m_axis_tdata_o,   // [23:0] sample_out
  output logic                    m_axis_tuser_o    // [0] captured
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic signed [SAMPLE_BITS-1:0] sample_out;

  assign cfg_ready_o    = 1'b1;
  assign m_axis_tdata_o = sample_out;

  shbc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  shbc_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    ($signed(s_axis_tdata_i)),
    .channel_i   (s_axis_tuser_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_o    (sample_out),
    .captured_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire
